>>> hdl/sbdt_pkg.sv
// ============================================================================
// Switch bank debounce package
// Shared widths, register indexes and the lane-to-merge update record.
// ============================================================================
package sbdt_pkg;

   // Fixed field widths.
   localparam int ValueWidth    = 4;
   localparam int TimeWidth     = 32;
   localparam int DebounceWidth = 16;
   localparam int CsrIndexWidth = 2;

   // Default number of debounce lanes.
   localparam int BitCountDefault = 4;

   // Configuration register indexes.
   localparam logic [CsrIndexWidth-1:0] CSR_DEBOUNCE_TIME = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_DIRECT_MODE   = 2'd1;

   // Register reset values.
   localparam logic [DebounceWidth-1:0] DebounceReset = 16'd20;

   // What one lane found for the current sample.
   typedef struct packed {
      logic rise;   // stable level goes from 0 to 1
      logic fall;   // stable level goes from 1 to 0
   } lane_update_type;

endpackage

>>> hdl/switch_bank_debounce_toggle.sv
// ============================================================================
// Switch bank debouncer with toggle mode
// Debounces a bank of switch bits in parallel lanes and merges the result.
// ============================================================================
// Usage:
//  - Request channel (req_valid, req_stall, req_raw_bits, req_now_time):
//    one raw switch sample and its millisecond timestamp per transfer.
//  - Response channel (rsp_valid, rsp_stall, rsp_value): one transfer per
//    sample carrying the debounced four-bit value after that sample.
//  - Configuration channel (csr_valid, csr_ready, csr_index, csr_data):
//    index 0 sets the debounce time in ms, index 1 selects direct mode.
//    csr_ready is always high; write only while the block is idle.
//  - A response is registered and appears in the cycle after its request transfer.
//  - Throughput is one sample per cycle while the receiver does not stall:
//    every bit lane does its timer subtract and compare in the same cycle and
//    the merge stage registers the result.
//  - While the receiver stalls, the held response stays and req_stall is
//    raised; a new sample is taken in the same cycle the response leaves.
//  - Reset clears all lane state and the value, sets the debounce time to
//    20 ms and selects toggle mode. No clearing pass is needed.
// ============================================================================
module switch_bank_debounce_toggle #(
   parameter int BitCount = sbdt_pkg::BitCountDefault
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [sbdt_pkg::ValueWidth-1:0]       req_raw_bits,
   input  logic [sbdt_pkg::TimeWidth-1:0]        req_now_time,
   // Response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [sbdt_pkg::ValueWidth-1:0]       rsp_value,
   // Configuration channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [sbdt_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [sbdt_pkg::DebounceWidth-1:0]    csr_data
);

   logic [sbdt_pkg::DebounceWidth-1:0]    debounce_time_ff, debounce_time_in;
   logic                                  direct_mode_ff, direct_mode_in;
   logic                                  accept;
   logic                                  first_load;
   sbdt_pkg::lane_update_type [BitCount-1:0] updates;

   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Configuration register writes.
   always_comb begin
      debounce_time_in = debounce_time_ff;
      direct_mode_in   = direct_mode_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            sbdt_pkg::CSR_DEBOUNCE_TIME: debounce_time_in = csr_data;
            sbdt_pkg::CSR_DIRECT_MODE:   direct_mode_in   = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_time_ff <= sbdt_pkg::DebounceReset;
         direct_mode_ff   <= 1'b0;
      end else begin
         debounce_time_ff <= debounce_time_in;
         direct_mode_ff   <= direct_mode_in;
      end
   end

   // One debounce lane per bit; lanes past the sample width see a low input.
   for (genvar i = 0; i < BitCount; i++) begin : g_lane
      logic lane_raw;
      if (i < sbdt_pkg::ValueWidth) begin : g_live
         assign lane_raw = req_raw_bits[i];
      end else begin : g_idle
         assign lane_raw = 1'b0;
      end

      sbdt_lane u_lane (
         .clock         (clock),
         .reset         (reset),
         .accept        (accept),
         .first_load    (first_load),
         .raw_bit       (lane_raw),
         .now_time      (req_now_time),
         .debounce_time (debounce_time_ff),
         .update        (updates[i])
      );
   end

   // Merge lane transitions into the value and register the response.
   sbdt_merge #(
      .BitCount (BitCount)
   ) u_merge (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .direct_mode (direct_mode_ff),
      .raw_bits    (req_raw_bits),
      .updates     (updates),
      .rsp_stall   (rsp_stall),
      .first_load  (first_load),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_value   (rsp_value)
   );

endmodule

>>> hdl/sbdt_lane.sv
// ============================================================================
// Switch bank debounce lane
// Debounces one switch bit: tracks the last raw level, the time of its last
// change and the stable level, and reports stable transitions.
// ============================================================================
module sbdt_lane (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic                                 first_load,
   input  logic                                 raw_bit,
   input  logic [sbdt_pkg::TimeWidth-1:0]       now_time,
   input  logic [sbdt_pkg::DebounceWidth-1:0]   debounce_time,
   output sbdt_pkg::lane_update_type            update
);

   logic                            prev_ff, prev_in;
   logic                            stable_ff, stable_in;
   logic [sbdt_pkg::TimeWidth-1:0]  stamp_ff, stamp_in;
   logic [sbdt_pkg::TimeWidth-1:0]  elapsed;
   logic                            settled;
   logic                            accepted_change;

   // Wrapped time since the last raw change, compared with the hold time.
   assign elapsed = now_time - stamp_ff;
   assign settled = elapsed >= {{(sbdt_pkg::TimeWidth-sbdt_pkg::DebounceWidth){1'b0}},
                                debounce_time};

   // A level becomes stable when it matches the previous raw level, differs
   // from the stable level and has been held long enough.
   assign accepted_change = (raw_bit == prev_ff) && (raw_bit != stable_ff) && settled;

   assign update.rise = accepted_change && raw_bit;
   assign update.fall = accepted_change && !raw_bit;

   // Next-state logic for the lane.
   always_comb begin
      prev_in   = prev_ff;
      stable_in = stable_ff;
      stamp_in  = stamp_ff;
      if (accept) begin
         if (first_load) begin
            prev_in   = raw_bit;
            stable_in = raw_bit;
         end else if (raw_bit != prev_ff) begin
            prev_in  = raw_bit;
            stamp_in = now_time;
         end else if (accepted_change) begin
            stable_in = raw_bit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= 1'b0;
         stable_ff <= 1'b0;
         stamp_ff  <= '0;
      end else begin
         prev_ff   <= prev_in;
         stable_ff <= stable_in;
         stamp_ff  <= stamp_in;
      end
   end

endmodule

>>> hdl/sbdt_merge.sv
// ============================================================================
// Switch bank debounce merge stage
// Combines the lane transitions into the logical value, handles the first
// direct-mode sample and holds the result register.
// ============================================================================
module sbdt_merge #(
   parameter int BitCount = sbdt_pkg::BitCountDefault
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  logic                                  direct_mode,
   input  logic [sbdt_pkg::ValueWidth-1:0]       raw_bits,
   input  sbdt_pkg::lane_update_type [BitCount-1:0] updates,
   input  logic                                  rsp_stall,
   output logic                                  first_load,
   output logic                                  req_stall,
   output logic                                  rsp_valid,
   output logic [sbdt_pkg::ValueWidth-1:0]       rsp_value
);

   logic                              first_seen_ff, first_seen_in;
   logic [sbdt_pkg::ValueWidth-1:0]   logical_ff, logical_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [sbdt_pkg::ValueWidth-1:0]   rsp_value_ff, rsp_value_in;
   logic [sbdt_pkg::ValueWidth-1:0]   rise_vec;
   logic [sbdt_pkg::ValueWidth-1:0]   fall_vec;

   // Lane results padded to the output width; missing lanes report nothing.
   for (genvar i = 0; i < sbdt_pkg::ValueWidth; i++) begin : g_pad
      if (i < BitCount) begin : g_lane
         assign rise_vec[i] = updates[i].rise;
         assign fall_vec[i] = updates[i].fall;
      end else begin : g_none
         assign rise_vec[i] = 1'b0;
         assign fall_vec[i] = 1'b0;
      end
   end

   // The first direct-mode sample is loaded as stable without timing.
   assign first_load = direct_mode && !first_seen_ff;

   // Take a new transfer whenever the result register is free or draining.
   assign req_stall = rsp_valid_ff && rsp_stall;

   // Logical value update.
   always_comb begin
      logical_in    = logical_ff;
      first_seen_in = first_seen_ff;
      if (accept) begin
         if (first_load) begin
            logical_in    = raw_bits;
            first_seen_in = 1'b1;
         end else if (direct_mode) begin
            logical_in = (logical_ff | rise_vec) & ~fall_vec;
         end else begin
            logical_in = logical_ff ^ rise_vec;
         end
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);
      rsp_value_in = accept ? logical_in : rsp_value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_seen_ff <= 1'b0;
         logical_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         first_seen_ff <= first_seen_in;
         logical_ff    <= logical_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

   // Every accepted sample produces a result in the next cycle.
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted sample did not produce a result");

   // The first direct sample is returned unchanged.
   a_first_load_value: assert property (@(posedge clock) disable iff (reset)
      (accept && first_load) |=> (rsp_value_ff == $past(raw_bits)))
      else $error("first direct sample not returned as value");

   // Once initialized, only reset clears the first-sample flag.
   a_first_seen_sticky: assert property (@(posedge clock) disable iff (reset)
      first_seen_ff |=> first_seen_ff)
      else $error("first-sample flag cleared without reset");

   // The logical value only moves on an accepted sample.
   a_logical_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(logical_ff))
      else $error("logical value changed without a sample");

endmodule
